// ----- rtl/stq_pkg.sv -----
package stq_pkg;

   localparam int CMD_W          = 2;
   localparam int ID_W           = 4;
   localparam int TIME_W         = 64;
   localparam int SCALE_W        = 30;
   localparam int NUM_TIMERS_DEF = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ARM    = 2'd0,
      CMD_CANCEL = 2'd1,
      CMD_RUN    = 2'd2
   } cmd_type;

   // one list entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] deadline;
   } entry_type;

   // signed a <= b on two's complement patterns
   function automatic logic le_signed(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
      le_signed = ($signed(a) <= $signed(b));
   endfunction

endpackage

// ----- rtl/sorted_timer_queue.sv -----
// Sorted deadline timer queue, one entry per armed timer, held in a one-port-write RAM.
// Arm: the shift-add multiplier scales the time, then a remove pass and an insert pass.
// Cancel: a remove pass. Run: a scan counts the due entries, each is sent as an expiry beat, then
// a pass compacts the list. One command at a time; req_stall stays high until the list walk is done.
// Reset (synchronous): list empty, clock enabled; RAM contents are not cleared.
module sorted_timer_queue #(
   parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [stq_pkg::CMD_W-1:0]          req_cmd,
   input  logic [stq_pkg::ID_W-1:0]           req_timer_id,
   input  logic signed [stq_pkg::TIME_W-1:0]  req_time_value,
   input  logic [stq_pkg::SCALE_W-1:0]        req_scale,
   // expiry channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [stq_pkg::ID_W-1:0]           rsp_expired_id,
   output logic signed [stq_pkg::TIME_W-1:0]  rsp_expired_deadline,
   output logic                               rsp_last_expired,
   // clock_enabled register
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_clock_enabled
);
   import stq_pkg::*;

   localparam int IDX_W = $clog2(NUM_TIMERS);
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_MUL       = 9'b000000010,  // waiting on the multiplier
      ST_RM        = 9'b000000100,  // remove pass, ascending
      ST_INS       = 9'b000001000,  // insert pass, descending
      ST_RUN_CNT   = 9'b000010000,  // count due entries
      ST_EMIT_RD   = 9'b000100000,
      ST_EMIT_LD   = 9'b001000000,
      ST_EMIT_WAIT = 9'b010000000,
      ST_CMP       = 9'b100000000   // close the gap left by the run
   } state_type;

   state_type         state_ff, state_in;
   logic              clk_en_ff, clk_en_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;        // armed entries
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;  // next read in a pass
   logic              pend_ff, pend_in;      // rd_data_ff valid for dat_idx_ff
   logic [CNT_W-1:0]  dat_idx_ff, dat_idx_in;
   logic              found_ff, found_in;
   logic [CNT_W-1:0]  hit_ff, hit_in;        // due entries in this run
   logic [CNT_W-1:0]  emit_ff, emit_in;
   logic [ID_W-1:0]   tid_ff, tid_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [TIME_W-1:0] key_ff, key_in;        // new deadline or run time

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [TIME_W-1:0] rsp_dl_ff, rsp_dl_in;
   logic              rsp_last_ff, rsp_last_in;

   // list RAM
   entry_type         mem [NUM_TIMERS];
   entry_type         rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;

   logic              mul_start;
   logic              mul_done;
   logic [TIME_W-1:0] mul_product;

   logic              le_hit;
   logic              rsp_take;
   logic [CNT_W-1:0]  dat_dec, dat_inc, dat_sub, ptr_dec, ptr_inc, emit_inc, cnt_left;

   stq_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .start      (mul_start),
      .time_value (req_time_value),
      .scale      (req_scale),
      .done       (mul_done),
      .product    (mul_product)
   );

   // the one shared compare: stored deadline against key
   assign le_hit   = le_signed(rd_data_ff.deadline, key_ff);
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   assign dat_dec  = dat_idx_ff - CNT_W'(1);
   assign dat_inc  = dat_idx_ff + CNT_W'(1);
   assign dat_sub  = dat_idx_ff - hit_ff;
   assign ptr_dec  = rd_ptr_ff - CNT_W'(1);
   assign ptr_inc  = rd_ptr_ff + CNT_W'(1);
   assign emit_inc = emit_ff + CNT_W'(1);
   assign cnt_left = cnt_ff - CNT_W'(found_ff);

   always_comb begin
      state_in     = state_ff;
      clk_en_in    = clk_en_ff;
      cnt_in       = cnt_ff;
      rd_ptr_in    = rd_ptr_ff;
      pend_in      = pend_ff;
      dat_idx_in   = dat_idx_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      emit_in      = emit_ff;
      tid_in       = tid_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_dl_in    = rsp_dl_ff;
      rsp_last_in  = rsp_last_ff;
      rd_addr      = rd_ptr_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data_ff;
      mul_start    = 1'b0;

      if (csr_valid) begin
         clk_en_in = csr_clock_enabled;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               tid_in    = req_timer_id;
               key_in    = req_time_value;
               rd_ptr_in = '0;
               pend_in   = 1'b0;
               found_in  = 1'b0;
               hit_in    = '0;
               unique case (req_cmd)
                  CMD_ARM: begin
                     mul_start = 1'b1;
                     state_in  = ST_MUL;
                  end
                  CMD_CANCEL: state_in = ST_RM;
                  CMD_RUN: begin
                     if (clk_en_ff) begin
                        state_in = ST_RUN_CNT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_MUL: begin
            if (mul_done) begin
               key_in   = mul_product;
               state_in = ST_RM;
            end
         end

         ST_RM: begin
            // once the timer is found, every later entry slides down one slot
            if (pend_ff) begin
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = dat_dec[IDX_W-1:0];
               end
               if (rd_data_ff.id == tid_ff) begin
                  found_in = 1'b1;
               end
            end
            if (rd_ptr_ff < cnt_ff) begin
               pend_in    = 1'b1;
               dat_idx_in = rd_ptr_ff;
               rd_ptr_in  = ptr_inc;
            end else begin
               pend_in = 1'b0;
            end
            if (!pend_ff && (rd_ptr_ff >= cnt_ff)) begin
               cnt_in = cnt_left;
               if ((cmd_ff == CMD_ARM) && (cnt_left < CNT_W'(NUM_TIMERS))) begin
                  rd_ptr_in = cnt_left;
                  state_in  = ST_INS;
               end else begin
                  state_in = ST_IDLE;   // cancel done, or full list drops the arm
               end
            end
         end

         ST_INS: begin
            // walk down from the tail, moving later deadlines up one slot
            rd_addr = ptr_dec[IDX_W-1:0];
            if (pend_ff && le_hit) begin
               wr_en    = 1'b1;
               wr_addr  = dat_inc[IDX_W-1:0];
               wr_data  = '{id: tid_ff, deadline: key_ff};
               cnt_in   = cnt_ff + CNT_W'(1);
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end else if (!pend_ff && (rd_ptr_ff == '0)) begin
               // new entry goes to the head
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = '{id: tid_ff, deadline: key_ff};
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_IDLE;
            end else begin
               if (pend_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = dat_inc[IDX_W-1:0];
               end
               if (rd_ptr_ff != '0) begin
                  pend_in    = 1'b1;
                  dat_idx_in = ptr_dec;
                  rd_ptr_in  = ptr_dec;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end

         ST_RUN_CNT: begin
            if ((pend_ff && !le_hit) || (!pend_ff && (rd_ptr_ff >= cnt_ff))) begin
               pend_in  = 1'b0;
               emit_in  = '0;
               state_in = (hit_ff == '0) ? ST_IDLE : ST_EMIT_RD;
            end else begin
               if (pend_ff) begin
                  hit_in = hit_ff + CNT_W'(1);
               end
               if (rd_ptr_ff < cnt_ff) begin
                  pend_in    = 1'b1;
                  dat_idx_in = rd_ptr_ff;
                  rd_ptr_in  = ptr_inc;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end

         ST_EMIT_RD: begin
            rd_addr  = emit_ff[IDX_W-1:0];
            state_in = ST_EMIT_LD;
         end

         ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_id_in    = rd_data_ff.id;
            rsp_dl_in    = rd_data_ff.deadline;
            rsp_last_in  = (emit_inc == hit_ff);
            state_in     = ST_EMIT_WAIT;
         end

         ST_EMIT_WAIT: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               emit_in      = emit_inc;
               if (emit_inc == hit_ff) begin
                  rd_ptr_in = hit_ff;
                  pend_in   = 1'b0;
                  state_in  = ST_CMP;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end

         ST_CMP: begin
            // survivors move down by the number of expired entries
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dat_sub[IDX_W-1:0];
            end
            if (rd_ptr_ff < cnt_ff) begin
               pend_in    = 1'b1;
               dat_idx_in = rd_ptr_ff;
               rd_ptr_in  = ptr_inc;
            end else begin
               pend_in = 1'b0;
            end
            if (!pend_ff && (rd_ptr_ff >= cnt_ff)) begin
               cnt_in   = cnt_ff - hit_ff;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clk_en_ff    <= 1'b1;
         cnt_ff       <= '0;
         rd_ptr_ff    <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         hit_ff       <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clk_en_ff    <= clk_en_in;
         cnt_ff       <= cnt_in;
         rd_ptr_ff    <= rd_ptr_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         hit_ff       <= hit_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dat_idx_ff  <= dat_idx_in;
      tid_ff      <= tid_in;
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_dl_ff   <= rsp_dl_in;
      rsp_last_ff <= rsp_last_in;
   end

   // list RAM: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_expired_id       = rsp_id_ff;
   assign rsp_expired_deadline = rsp_dl_ff;
   assign rsp_last_expired     = rsp_last_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(NUM_TIMERS))
      else $error("armed count above list depth");

   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_EMIT_WAIT))
      else $error("expiry beat outside emit wait");

   a_arm_mul: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_cmd == CMD_ARM)) |=> (state_ff == ST_MUL))
      else $error("arm did not start multiplier");

   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == ST_RM) || (state_ff == ST_INS) || (state_ff == ST_CMP)))
      else $error("list write outside a list pass");

   a_last_cmp: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last_ff) |=> (state_ff == ST_CMP))
      else $error("last expiry did not start compaction");

endmodule

// ----- rtl/stq_mul.sv -----
module stq_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [stq_pkg::TIME_W-1:0]  time_value,
   input  logic [stq_pkg::SCALE_W-1:0] scale,
   output logic                        done,
   output logic [stq_pkg::TIME_W-1:0]  product
);
   import stq_pkg::*;

   localparam int ACC_W  = TIME_W + SCALE_W;
   localparam int STEP_W = $clog2(SCALE_W);
   localparam logic [TIME_W-1:0] MOST_NEG = {1'b1, {(TIME_W-1){1'b0}}};
   localparam logic [TIME_W-1:0] MOST_POS = {1'b0, {(TIME_W-1){1'b1}}};

   logic                busy_ff, busy_in;
   logic                fin_ff, fin_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [TIME_W-1:0]   mag_ff, mag_in;
   logic [SCALE_W-1:0]  sc_ff, sc_in;
   logic                neg_ff, neg_in;
   logic [TIME_W-1:0]   prod_ff, prod_in;
   logic                over;
   logic [TIME_W-1:0]   sat_mag;

   // magnitude above the limit of the sign's range
   always_comb begin
      if (neg_ff) begin
         over = (|acc_ff[ACC_W-1:TIME_W]) ||
                (acc_ff[TIME_W-1] && (|acc_ff[TIME_W-2:0]));
      end else begin
         over = |acc_ff[ACC_W-1:TIME_W-1];
      end
      if (over) begin
         sat_mag = neg_ff ? MOST_NEG : MOST_POS;
      end else begin
         sat_mag = acc_ff[TIME_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      step_in = step_ff;
      acc_in  = acc_ff;
      mag_in  = mag_ff;
      sc_in   = sc_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      if (start) begin
         neg_in  = time_value[TIME_W-1];
         mag_in  = time_value[TIME_W-1] ? (~time_value + TIME_W'(1)) : time_value;
         acc_in  = '0;
         sc_in   = scale;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift-add, scale MSB first
         acc_in  = {acc_ff[ACC_W-2:0], 1'b0} +
                   (sc_ff[SCALE_W-1] ? {{SCALE_W{1'b0}}, mag_ff} : ACC_W'(0));
         sc_in   = {sc_ff[SCALE_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SCALE_W - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         prod_in = neg_ff ? (~sat_mag + TIME_W'(1)) : sat_mag;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      mag_ff  <= mag_in;
      sc_ff   <= sc_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule
